// ===== hw/rtl/rtfl_pkg.sv =====
// Shared types, constants and helper functions for the RTF byte lexer.
`default_nettype none

package rtfl_pkg;

  // Lexer limits.
  localparam logic [5:0] MAX_WORD_LEN = 6'd63;
  localparam logic [7:0] MAX_DEPTH    = 8'd255;
  localparam logic [35:0] MAG_LIMIT   = 36'h0_8000_0000;
  localparam logic [31:0] POS_LIMIT   = 32'h7FFF_FFFF;

  // Characters with a special meaning.
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_QUOTE  = 8'h27;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [4:0] HEX_NONE  = 5'd16;

  typedef enum logic [2:0] {
    MODE_NORMAL = 3'd0,
    MODE_BINARY = 3'd1,
    MODE_HEX_A  = 3'd2,
    MODE_HEX_B  = 3'd3,
    MODE_WORD   = 3'd4,
    MODE_PARAM  = 3'd5
  } lex_mode_e;

  typedef enum logic [3:0] {
    TK_TEXT    = 4'd0,
    TK_OPEN    = 4'd1,
    TK_CLOSE   = 4'd2,
    TK_LETTER  = 4'd3,
    TK_WORDEND = 4'd4,
    TK_SYMBOL  = 4'd5,
    TK_HEX     = 4'd6,
    TK_BINARY  = 4'd7,
    TK_ABANDON = 4'd8,
    TK_UNBAL   = 4'd9
  } tok_kind_e;

  // Architectural lexer state.
  typedef struct packed {
    lex_mode_e   mode;
    logic [5:0]  word_len;
    logic [1:0]  bin_match;
    logic [4:0]  hex_nib;
    logic [31:0] accum;
    logic        neg;
    logic [30:0] bin_rem;
    logic [7:0]  depth;
  } lex_state_t;

  // One token as it travels to the output.
  typedef struct packed {
    tok_kind_e   kind;
    logic [7:0]  tbyte;
    logic        has_param;
    logic [31:0] param;
    logic [7:0]  depth;
    logic        last;
  } tok_t;

  // Result of a byte seen in normal data.
  typedef struct packed {
    logic       emit;
    tok_kind_e  kind;
    logic [7:0] tbyte;
    logic [7:0] depth;
    logic       to_word;
  } norm_t;

  function automatic logic is_letter(logic [7:0] b);
    return (b >= 8'h41 && b <= 8'h5A) || (b >= 8'h61 && b <= 8'h7A);
  endfunction

  function automatic logic is_digit(logic [7:0] b);
    return b >= 8'h30 && b <= 8'h39;
  endfunction

  // Hex digit value, or HEX_NONE when the byte is no hex digit.
  function automatic logic [4:0] hex_value(logic [7:0] b);
    logic [7:0] v;
    v = 8'd0;
    if (is_digit(b)) begin
      v = b - 8'h30;
    end else if (b >= 8'h61 && b <= 8'h66) begin
      v = b - 8'h57;
    end else if (b >= 8'h41 && b <= 8'h46) begin
      v = b - 8'h37;
    end else begin
      v = {3'd0, HEX_NONE};
    end
    return v[4:0];
  endfunction

  // Letters of the binary-run keyword.
  function automatic logic [7:0] bin_char(logic [1:0] idx);
    logic [7:0] c;
    case (idx)
      2'd0:    c = 8'h62;
      2'd1:    c = 8'h69;
      default: c = 8'h6E;
    endcase
    return c;
  endfunction

  function automatic tok_t mk_tok(tok_kind_e kind, logic [7:0] tbyte, logic hp,
                                  logic [31:0] pv, logic [7:0] depth);
    tok_t t;
    t.kind      = kind;
    t.tbyte     = tbyte;
    t.has_param = hp;
    t.param     = pv;
    t.depth     = depth;
    t.last      = 1'b0;
    return t;
  endfunction

  // Handling of a byte in normal data: braces, backslash, dropped line ends, text.
  function automatic norm_t do_normal(logic [7:0] b, logic [7:0] depth);
    norm_t r;
    r.emit    = 1'b1;
    r.kind    = TK_TEXT;
    r.tbyte   = b;
    r.depth   = depth;
    r.to_word = 1'b0;
    if (b == CH_LBRACE) begin
      r.kind  = TK_OPEN;
      r.tbyte = 8'd0;
      if (depth < MAX_DEPTH) begin
        r.depth = depth + 8'd1;
      end
    end else if (b == CH_RBRACE) begin
      r.tbyte = 8'd0;
      if (depth == 8'd0) begin
        r.kind = TK_UNBAL;
      end else begin
        r.kind  = TK_CLOSE;
        r.depth = depth - 8'd1;
      end
    end else if (b == CH_BSLASH) begin
      r.emit    = 1'b0;
      r.to_word = 1'b1;
    end else if (b == CH_CR || b == CH_LF) begin
      r.emit = 1'b0;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/rtfl_step.sv =====
// Next-state and token logic for one input byte of the RTF lexer.
`default_nettype none

module rtfl_step (
  input  rtfl_pkg::lex_state_t st_i,
  input  logic [7:0]           byte_i,
  output rtfl_pkg::lex_state_t st_o,
  output rtfl_pkg::tok_t       tok0_o,
  output rtfl_pkg::tok_t       tok1_o,
  output logic [1:0]           push_n_o
);
  import rtfl_pkg::*;

  lex_state_t  nxt;
  tok_t        t0;
  tok_t        t1;
  logic [1:0]  n;
  logic        end_w;
  logic        with_p;
  logic [31:0] pv;
  logic        run;
  norm_t       nr;
  logic [4:0]  second;
  logic [7:0]  hexv;
  logic [35:0] acc_next;

  // Per-mode handling of the byte; control-word end is finished below.
  always_comb begin
    nxt      = st_i;
    t0       = mk_tok(TK_TEXT, 8'd0, 1'b0, 32'd0, st_i.depth);
    t1       = mk_tok(TK_TEXT, 8'd0, 1'b0, 32'd0, st_i.depth);
    n        = 2'd0;
    end_w    = 1'b0;
    with_p   = 1'b0;
    pv       = 32'd0;
    run      = 1'b0;
    nr       = do_normal(byte_i, st_i.depth);
    second   = hex_value(byte_i);
    hexv     = 8'd0;
    acc_next = ({4'd0, st_i.accum} << 3) + ({4'd0, st_i.accum} << 1)
               + {28'd0, byte_i - 8'h30};

    case (st_i.mode)
      MODE_BINARY: begin
        t0 = mk_tok(TK_BINARY, byte_i, 1'b0, 32'd0, st_i.depth);
        n  = 2'd1;
        if (st_i.bin_rem <= 31'd1) begin
          nxt.bin_rem = 31'd0;
          nxt.mode    = MODE_NORMAL;
        end else begin
          nxt.bin_rem = st_i.bin_rem - 31'd1;
        end
      end
      MODE_HEX_A: begin
        nxt.hex_nib = second;
        nxt.mode    = MODE_HEX_B;
      end
      MODE_HEX_B: begin
        if (st_i.hex_nib >= HEX_NONE) begin
          hexv = 8'd0;
        end else if (second >= HEX_NONE) begin
          hexv = {4'd0, st_i.hex_nib[3:0]};
        end else begin
          hexv = {st_i.hex_nib[3:0], second[3:0]};
        end
        nxt.mode = MODE_NORMAL;
        t0       = mk_tok(TK_HEX, hexv, 1'b0, 32'd0, st_i.depth);
        n        = 2'd1;
      end
      MODE_WORD: begin
        if (is_letter(byte_i)) begin
          n = 2'd1;
          if (st_i.word_len >= MAX_WORD_LEN) begin
            nxt.mode = MODE_NORMAL;
            t0       = mk_tok(TK_ABANDON, 8'd0, 1'b0, 32'd0, st_i.depth);
          end else begin
            if (st_i.word_len < 6'd3 && {4'd0, st_i.bin_match} == st_i.word_len
                && byte_i == bin_char(st_i.word_len[1:0])) begin
              nxt.bin_match = st_i.bin_match + 2'd1;
            end
            nxt.word_len = st_i.word_len + 6'd1;
            t0           = mk_tok(TK_LETTER, byte_i, 1'b0, 32'd0, st_i.depth);
          end
        end else if (st_i.word_len == 6'd0) begin
          if (byte_i == CH_QUOTE) begin
            nxt.mode = MODE_HEX_A;
          end else begin
            nxt.mode = MODE_NORMAL;
            t0       = mk_tok(TK_SYMBOL, byte_i, 1'b0, 32'd0, st_i.depth);
            n        = 2'd1;
          end
        end else if (byte_i == CH_MINUS || is_digit(byte_i)) begin
          nxt.mode  = MODE_PARAM;
          nxt.neg   = (byte_i == CH_MINUS);
          nxt.accum = is_digit(byte_i) ? {24'd0, byte_i - 8'h30} : 32'd0;
        end else begin
          end_w = 1'b1;
        end
      end
      MODE_PARAM: begin
        if (is_digit(byte_i)) begin
          nxt.accum = (acc_next > MAG_LIMIT) ? MAG_LIMIT[31:0] : acc_next[31:0];
        end else begin
          end_w  = 1'b1;
          with_p = 1'b1;
        end
      end
      default: begin
        nxt.mode  = MODE_NORMAL;
        nxt.depth = nr.depth;
        if (nr.to_word) begin
          nxt.mode      = MODE_WORD;
          nxt.word_len  = 6'd0;
          nxt.bin_match = 2'd0;
        end
        if (nr.emit) begin
          t0 = mk_tok(nr.kind, nr.tbyte, 1'b0, 32'd0, nr.depth);
          n  = 2'd1;
        end
      end
    endcase

    // Control-word end, then the terminator unless it is a space.
    if (end_w) begin
      if (with_p) begin
        if (st_i.neg) begin
          pv = 32'd0 - st_i.accum;
        end else begin
          pv  = (st_i.accum > POS_LIMIT) ? POS_LIMIT : st_i.accum;
          run = (pv != 32'd0) && st_i.word_len == 6'd3 && st_i.bin_match == 2'd3;
        end
      end
      t0 = mk_tok(TK_WORDEND, 8'd0, with_p, pv, st_i.depth);
      n  = 2'd1;
      if (run) begin
        nxt.mode    = MODE_BINARY;
        nxt.bin_rem = pv[30:0];
      end else begin
        nxt.mode = MODE_NORMAL;
      end
      if (byte_i != CH_SPACE) begin
        if (run) begin
          t1 = mk_tok(TK_BINARY, byte_i, 1'b0, 32'd0, st_i.depth);
          n  = 2'd2;
          if (pv <= 32'd1) begin
            nxt.bin_rem = 31'd0;
            nxt.mode    = MODE_NORMAL;
          end else begin
            nxt.bin_rem = pv[30:0] - 31'd1;
          end
        end else begin
          nxt.depth = nr.depth;
          if (nr.to_word) begin
            nxt.mode      = MODE_WORD;
            nxt.word_len  = 6'd0;
            nxt.bin_match = 2'd0;
          end
          if (nr.emit) begin
            t1 = mk_tok(nr.kind, nr.tbyte, 1'b0, 32'd0, nr.depth);
            n  = 2'd2;
          end
        end
      end
    end

    // Mark the final token of this byte.
    t0.last = (n == 2'd1);
    t1.last = 1'b1;
  end

  assign st_o     = nxt;
  assign tok0_o   = t0;
  assign tok1_o   = t1;
  assign push_n_o = n;

endmodule

`default_nettype wire

// ===== hw/rtl/rtfl_tokq.sv =====
// Four-entry token queue that takes up to two tokens and gives one per beat while not stalled.
`default_nettype none

module rtfl_tokq (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  rtfl_pkg::tok_t tok0_i,
  input  rtfl_pkg::tok_t tok1_i,
  input  logic [1:0]     push_n_i,
  output logic           room_o,
  output rtfl_pkg::tok_t head_o,
  output logic           valid_o,
  input  logic           stall_i
);
  import rtfl_pkg::*;

  localparam logic [2:0] QDEPTH = 3'd4;

  tok_t       mem [4];
  logic [1:0] wr_q;
  logic [1:0] wr_d;
  logic [1:0] rd_q;
  logic [1:0] rd_d;
  logic [2:0] cnt_q;
  logic [2:0] cnt_d;
  logic       pop;

  assign pop     = valid_o && !stall_i;
  assign valid_o = (cnt_q != 3'd0);
  assign room_o  = (cnt_q <= QDEPTH - 3'd2);
  assign head_o  = mem[rd_q];

  // Pointer and fill count update.
  always_comb begin
    wr_d  = wr_q + push_n_i;
    rd_d  = rd_q + {1'b0, pop};
    cnt_d = cnt_q + {1'b0, push_n_i} - {2'd0, pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 2'd0;
      rd_q  <= 2'd0;
      cnt_q <= 3'd0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  // Token storage.
  always_ff @(posedge clk_i) begin
    if (push_n_i != 2'd0) begin
      mem[wr_q] <= tok0_i;
    end
    if (push_n_i == 2'd2) begin
      mem[wr_q + 2'd1] <= tok1_i;
    end
  end

  // The fill count never passes the queue size.
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= QDEPTH)
    else $error("token queue count out of range");

  // Tokens are only pushed when there is room for them.
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_n_i != 2'd0) |-> ({1'b0, cnt_q} + {2'd0, push_n_i} <= {1'b0, QDEPTH}))
    else $error("token queue overflow");

  // The pointers stay consistent with the fill count.
  a_ptr_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (wr_q - rd_q) == cnt_q[1:0])
    else $error("token queue pointers disagree with count");

endmodule

`default_nettype wire

// ===== hw/rtl/rtf_byte_lexer.sv =====
// Top level of the RTF byte lexer: state registers, step logic and token queue.
//
// Usage:
//   The input channel takes one raw RTF byte per beat (in_valid_i, in_stall_o,
//   in_byte_i). The output channel gives one token per beat (out_valid_o,
//   out_stall_i and the token fields). A byte yields zero, one or two tokens;
//   last_of_item_o marks the final token of a byte.
//   A token enters the token queue when its byte is accepted. The input takes
//   one byte per cycle while each byte yields at most one token and the
//   receiver does not stall; bytes with two tokens fill the queue. The rate is
//   set by the four-entry token queue, which takes a byte only while it has
//   room for two tokens.
//   Reset puts the lexer in normal data at nesting depth zero with an empty
//   queue. When the receiver stalls, the head token holds; the queue keeps
//   taking bytes until it is nearly full, then in_stall_o rises.
`default_nettype none

module rtf_byte_lexer (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [7:0]         in_byte_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [3:0]         token_kind_o,
  output logic [7:0]         token_byte_o,
  output logic               has_param_o,
  output logic signed [31:0] param_value_o,
  output logic [7:0]         group_depth_o,
  output logic               last_of_item_o
);
  import rtfl_pkg::*;

  lex_state_t st_q;
  lex_state_t st_d;
  tok_t       tok0;
  tok_t       tok1;
  tok_t       head;
  logic [1:0] push_raw;
  logic [1:0] push_n;
  logic       room;
  logic       in_fire;

  assign in_stall_o = !room;
  assign in_fire    = in_valid_i && room;
  assign push_n     = in_fire ? push_raw : 2'd0;

  // Per-byte lexing logic.
  rtfl_step u_step (
    .st_i     (st_q),
    .byte_i   (in_byte_i),
    .st_o     (st_d),
    .tok0_o   (tok0),
    .tok1_o   (tok1),
    .push_n_o (push_raw)
  );

  // Lexer state register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= '{mode: MODE_NORMAL, default: '0};
    end else if (in_fire) begin
      st_q <= st_d;
    end
  end

  // Output token queue.
  rtfl_tokq u_tokq (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .tok0_i   (tok0),
    .tok1_i   (tok1),
    .push_n_i (push_n),
    .room_o   (room),
    .head_o   (head),
    .valid_o  (out_valid_o),
    .stall_i  (out_stall_i)
  );

  assign token_kind_o   = head.kind;
  assign token_byte_o   = head.tbyte;
  assign has_param_o    = head.has_param;
  assign param_value_o  = head.param;
  assign group_depth_o  = head.depth;
  assign last_of_item_o = head.last;

  // A binary run always has bytes left to consume.
  a_bin_rem: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q.mode == MODE_BINARY) |-> (st_q.bin_rem != 31'd0))
    else $error("binary mode with empty run");

  // The second hex byte always returns the lexer to normal data.
  a_hex_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && st_q.mode == MODE_HEX_B) |=> (st_q.mode == MODE_NORMAL))
    else $error("hex escape did not finish");

  // A word is never longer than the word limit.
  a_word_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q.word_len <= MAX_WORD_LEN && st_q.bin_match <= 2'd3
    && {4'd0, st_q.bin_match} <= st_q.word_len)
    else $error("control word length out of range");

endmodule

`default_nettype wire
